/* hw/rtl/ast_pkg.sv */
// shared types, codes and constants of the alarm slot table
// no dependencies; compiled before every other file of the block
package ast_pkg;

   // default table size and field widths
   localparam int ENTRIES_DEF = 20;
   localparam int ACT_W       = 2;
   localparam int ERR_W       = 8;
   localparam int ID_W        = 16;
   localparam int TIME_W      = 32;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   // request actions
   localparam logic [ACT_W-1:0] ACT_SET    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;
   localparam logic [ACT_W-1:0] ACT_WALK   = 2'd3;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_ERR_MASK    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_MASK = 1'd1;
   localparam logic [ID_W-1:0]      ERR_MASK_RST    = 16'h00FF;
   localparam logic [ID_W-1:0]      ORIGIN_MASK_RST = 16'hFF00;

   // response status codes
   localparam logic STS_DONE      = 1'b0;
   localparam logic STS_NO_EFFECT = 1'b1;

   // what the output register is loaded with
   localparam logic [1:0] EMIT_BUILT = 2'd0;   // built id and request time
   localparam logic [1:0] EMIT_SLOT  = 2'd1;   // id and time of the current slot
   localparam logic [1:0] EMIT_NONE  = 2'd2;   // zero id and time

   // commands from the controller to the datapath
   typedef struct packed {
      logic       capture;
      logic       scan_inc;
      logic       set_wr;
      logic       clr_wr;
      logic       emit;
      logic [1:0] emit_kind;
      logic       emit_status;
      logic       emit_last;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             full;
      logic             id_match;
      logic             err_match;
      logic             slot_nz;
      logic             later_nz;
      logic             idx_last;
      logic             out_free;
   } status_type;

   // type A alarm ids
   function automatic logic is_type_a(input logic [ID_W-1:0] id);
      logic hit;
      case (id) inside
         16'h1002, 16'h1003, [16'h1008:16'h100D], 16'h100F, [16'h1011:16'h1014]: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

/* hw/rtl/ast_ifs.sv */
// request and response channel interfaces of the alarm slot table
// depends on ast_pkg for field widths
interface ast_req_if;
   import ast_pkg::*;

   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [ERR_W-1:0]  error_num;
   logic [ID_W-1:0]   origin_code;
   logic [TIME_W-1:0] now_epoch;

   modport source (output valid, action, error_num, origin_code, now_epoch, input ready);
   modport sink   (input valid, action, error_num, origin_code, now_epoch, output ready);
endinterface

interface ast_rsp_if;
   import ast_pkg::*;

   logic              valid;
   logic              ready;
   logic              status;
   logic [ID_W-1:0]   entry_id;
   logic [TIME_W-1:0] stamp;
   logic              type_a_present;
   logic              last;

   modport source (output valid, status, entry_id, stamp, type_a_present, last, input ready);
   modport sink   (input valid, status, entry_id, stamp, type_a_present, last, output ready);
endinterface

/* hw/rtl/ast_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module ast_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 20
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ast_ctrl.sv */
// sequencer of the alarm slot table: accepts requests, steps the slot scan
// depends on ast_pkg for command and status types and action codes
module ast_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [ast_pkg::ACT_W-1:0] req_action,
   output logic                     req_ready,
   input  ast_pkg::status_type      sts,
   output ast_pkg::cmd_type         cmd
);
   import ast_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SET  = 2'd1;
   localparam logic [1:0] S_RD   = 2'd2;
   localparam logic [1:0] S_EV   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_action == ACT_SET) ? S_SET : S_RD;
            end
         end
         S_SET: begin
            if (sts.out_free) begin
               cmd.set_wr      = 1'b1;
               cmd.emit        = 1'b1;
               cmd.emit_kind   = EMIT_BUILT;
               cmd.emit_status = sts.full ? STS_NO_EFFECT : STS_DONE;
               cmd.emit_last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_RD: begin
            // slot data arrives from the rams at the next edge
            state_in = S_EV;
         end
         S_EV: begin
            case (sts.action)
               ACT_CLEAR: begin
                  if (sts.id_match || sts.idx_last) begin
                     if (sts.out_free) begin
                        cmd.clr_wr      = sts.id_match;
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = EMIT_BUILT;
                        cmd.emit_status = sts.id_match ? STS_DONE : STS_NO_EFFECT;
                        cmd.emit_last   = 1'b1;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     cmd.scan_inc = 1'b1;
                     state_in     = S_RD;
                  end
               end
               ACT_LOOKUP: begin
                  if (sts.err_match || sts.idx_last) begin
                     if (sts.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = sts.err_match ? EMIT_SLOT : EMIT_NONE;
                        cmd.emit_status = sts.err_match ? STS_DONE : STS_NO_EFFECT;
                        cmd.emit_last   = 1'b1;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     cmd.scan_inc = 1'b1;
                     state_in     = S_RD;
                  end
               end
               default: begin
                  // walk: occupied slots in order, empty table gives one no-effect
                  if (sts.slot_nz) begin
                     if (sts.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = EMIT_SLOT;
                        cmd.emit_status = STS_DONE;
                        cmd.emit_last   = !sts.later_nz;
                        if (sts.later_nz) begin
                           cmd.scan_inc = 1'b1;
                           state_in     = S_RD;
                        end else begin
                           state_in = S_IDLE;
                        end
                     end
                  end else if (sts.idx_last) begin
                     if (sts.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_kind   = EMIT_NONE;
                        cmd.emit_status = STS_NO_EFFECT;
                        cmd.emit_last   = 1'b1;
                        state_in        = S_IDLE;
                     end
                  end else begin
                     cmd.scan_inc = 1'b1;
                     state_in     = S_RD;
                  end
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/ast_datapath.sv */
// datapath of the alarm slot table: mask registers, request register, slot rams,
// per-slot flags, scan index and response register
// depends on ast_pkg and ast_ram
module ast_datapath #(
   parameter int ENTRIES = ast_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [ast_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ast_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [ast_pkg::ACT_W-1:0]      req_action,
   input  logic [ast_pkg::ERR_W-1:0]      req_error_num,
   input  logic [ast_pkg::ID_W-1:0]       req_origin_code,
   input  logic [ast_pkg::TIME_W-1:0]     req_now_epoch,
   input  ast_pkg::cmd_type               cmd,
   output ast_pkg::status_type            sts,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_status,
   output logic [ast_pkg::ID_W-1:0]       rsp_entry_id,
   output logic [ast_pkg::TIME_W-1:0]     rsp_stamp,
   output logic                          rsp_type_a_present,
   output logic                          rsp_last
);
   import ast_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // mask registers
   logic [ID_W-1:0] err_mask_ff;
   logic [ID_W-1:0] origin_mask_ff;

   // captured request
   logic [ACT_W-1:0]  act_ff;
   logic [ERR_W-1:0]  err_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] now_ff;

   // scan index and per-slot flags
   logic [AW-1:0]      idx_ff;
   logic [AW-1:0]      idx_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] nz_ff, nz_in;
   logic [ENTRIES-1:0] ta_ff, ta_in;

   // ram ports
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     set_idx;
   logic [ID_W-1:0]   wr_id;
   logic [TIME_W-1:0] wr_time;
   logic [ID_W-1:0]   ram_id;
   logic [TIME_W-1:0] ram_time;
   logic [ID_W-1:0]   slot_id;
   logic [TIME_W-1:0] slot_time;
   logic              full;
   logic              later_nz;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [TIME_W-1:0] rsp_stamp_ff, rsp_stamp_in;
   logic              rsp_ta_ff;
   logic              rsp_last_ff;
   logic              out_free;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         err_mask_ff    <= ERR_MASK_RST;
         origin_mask_ff <= ORIGIN_MASK_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ERR_MASK:    err_mask_ff    <= csr_wdata;
            CSR_ORIGIN_MASK: origin_mask_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request capture with the built alarm id
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         err_ff <= req_error_num;
         id_ff  <= (ID_W'(req_error_num) & err_mask_ff) | (req_origin_code & origin_mask_ff);
         now_ff <= req_now_epoch;
      end
   end

   // lowest empty slot and fullness
   always_comb begin
      set_idx = '0;
      for (int j = ENTRIES - 1; j >= 0; j--) begin
         if (!nz_ff[j]) begin
            set_idx = AW'(j);
         end
      end
   end
   assign full = &nz_ff;

   // occupied slot above the scan index
   always_comb begin
      later_nz = 1'b0;
      for (int j = 0; j < ENTRIES; j++) begin
         if (nz_ff[j] && (AW'(j) > idx_ff)) begin
            later_nz = 1'b1;
         end
      end
   end

   // table write: set at the lowest empty slot, clear at the scan index
   assign wr_en   = (cmd.set_wr && !full) || cmd.clr_wr;
   assign wr_addr = cmd.set_wr ? set_idx : idx_ff;
   assign wr_id   = cmd.set_wr ? id_ff : '0;
   assign wr_time = cmd.set_wr ? now_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      nz_in    = nz_ff;
      ta_in    = ta_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
         nz_in[wr_addr]    = (wr_id != '0);
         ta_in[wr_addr]    = is_type_a(wr_id);
      end
   end

   // scan index
   always_comb begin
      idx_in = idx_ff;
      if (cmd.capture) begin
         idx_in = '0;
      end else if (cmd.scan_inc) begin
         idx_in = idx_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         nz_ff    <= '0;
         ta_ff    <= '0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         nz_ff    <= nz_in;
         ta_ff    <= ta_in;
         idx_ff   <= idx_in;
      end
   end

   // slot storage
   ast_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_id_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_id),
      .rd_addr (idx_ff),
      .rd_data (ram_id)
   );

   ast_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_time_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_time),
      .rd_addr (idx_ff),
      .rd_data (ram_time)
   );

   // never written slots read as empty
   assign slot_id   = valid_ff[idx_ff] ? ram_id : '0;
   assign slot_time = valid_ff[idx_ff] ? ram_time : '0;

   // status to the controller
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign sts.action    = act_ff;
   assign sts.full      = full;
   assign sts.id_match  = (slot_id == id_ff);
   assign sts.err_match = ((slot_id & err_mask_ff) == ID_W'(err_ff));
   assign sts.slot_nz   = nz_ff[idx_ff];
   assign sts.later_nz  = later_nz;
   assign sts.idx_last  = (idx_ff == AW'(ENTRIES - 1));
   assign sts.out_free  = out_free;

   // response payload select
   always_comb begin
      case (cmd.emit_kind)
         EMIT_BUILT: begin
            rsp_id_in    = id_ff;
            rsp_stamp_in = now_ff;
         end
         EMIT_SLOT: begin
            rsp_id_in    = slot_id;
            rsp_stamp_in = slot_time;
         end
         default: begin
            rsp_id_in    = '0;
            rsp_stamp_in = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_id_ff     <= rsp_id_in;
         rsp_stamp_ff  <= rsp_stamp_in;
         rsp_ta_ff     <= |ta_in;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_entry_id       = rsp_id_ff;
   assign rsp_stamp          = rsp_stamp_ff;
   assign rsp_type_a_present = rsp_ta_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

/* hw/rtl/alarm_slot_table_unit.sv */
// top level of the alarm slot table: controller plus datapath
// depends on ast_pkg, ast_ifs, ast_ctrl, ast_datapath and ast_ram

// A table of ENTRIES alarm slots, each a 16-bit id and a 32-bit time, empty
// after reset with no clearing pass (per-slot valid bits). One request is worked
// at a time; the next is taken once the last response of the current one is in
// the output register. A set takes its free slot from the per-slot occupancy
// flags. Clear and lookup scan the slots through the single read port of the
// slot rams until a slot decides or the last slot is reached. A walk visits
// every slot up to the last occupied one and gives one response per occupied
// slot, the final one flagged last; an empty table gives a single no-effect
// response. A held response stalls the scan. The user must write the mask
// registers through the csr port only while no request is in progress; the
// block itself does not enforce it.
module alarm_slot_table_unit #(
   parameter int ENTRIES = ast_pkg::ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [ast_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ast_pkg::CSR_DATA_W-1:0] csr_wdata,
   ast_req_if.sink                       req_if,
   ast_rsp_if.source                     rsp_if
);
   import ast_pkg::*;

   cmd_type    cmd;
   status_type sts;

   // sequencer
   ast_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (req_if.action),
      .req_ready  (req_if.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // table and response path
   ast_datapath #(.ENTRIES(ENTRIES)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_action         (req_if.action),
      .req_error_num      (req_if.error_num),
      .req_origin_code    (req_if.origin_code),
      .req_now_epoch      (req_if.now_epoch),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_ready          (rsp_if.ready),
      .rsp_valid          (rsp_if.valid),
      .rsp_status         (rsp_if.status),
      .rsp_entry_id       (rsp_if.entry_id),
      .rsp_stamp          (rsp_if.stamp),
      .rsp_type_a_present (rsp_if.type_a_present),
      .rsp_last           (rsp_if.last)
   );

endmodule

/* dv/alarm_slot_table_unit_tb.sv */
// self-checking testbench of the alarm slot table unit
// depends on ast_pkg, ast_ifs and the alarm_slot_table_unit rtl
module alarm_slot_table_unit_tb;
   import ast_pkg::*;

   localparam int ENTRIES        = ENTRIES_DEF;
   localparam int SETTLE         = 2 * ENTRIES + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES         = 7;
   localparam int PHASE_ITEMS    = 42;
   localparam int NROWS          = 25;
   localparam int REPORT_MAX     = 10;
   localparam int LOG_DEPTH      = 64;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [ERR_W-1:0]  err;
      logic [ID_W-1:0]   origin;
      logic [TIME_W-1:0] epoch;
   } alarm_req_type;

   typedef struct packed {
      logic              status;
      logic [ID_W-1:0]   entry_id;
      logic [TIME_W-1:0] stamp;
      logic              type_a;
      logic              last;
   } alarm_rsp_type;

   typedef struct packed {
      alarm_req_type req;
      int            reps;
      bit            typed;
      alarm_rsp_type rsp;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ast_req_if req_ch ();
   ast_rsp_if rsp_ch ();

   alarm_slot_table_unit #(.ENTRIES(ENTRIES)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch)
   );

   // shadow copy of the slot table and mask registers
   logic [ID_W-1:0]   slot_id   [ENTRIES];
   logic [TIME_W-1:0] slot_time [ENTRIES];
   logic [ID_W-1:0]   err_mask;
   logic [ID_W-1:0]   origin_mask;

   alarm_rsp_type step_rsp [$];
   alarm_rsp_type owed_rsp [$];
   logic [ERR_W+ID_W-1:0] set_log [$];
   plan_row_type plan [NROWS];

   int send_idle_pct;
   int recv_stall_pct;
   int mismatch_count;
   int quiet_cycles;

   always #10 clock = ~clock;

   function automatic logic alarm_is_type_a(input logic [ID_W-1:0] id);
      return (id == 16'h1002) || (id == 16'h1003) || (id == 16'h100F) ||
             (id >= 16'h1008 && id <= 16'h100D) || (id >= 16'h1011 && id <= 16'h1014);
   endfunction

   function automatic void note_rsp(input logic sts, input logic [ID_W-1:0] id,
                                    input logic [TIME_W-1:0] stamp, input logic last);
      alarm_rsp_type r;
      int i;
      r.status   = sts;
      r.entry_id = id;
      r.stamp    = stamp;
      r.last     = last;
      r.type_a   = 1'b0;
      for (i = 0; i < ENTRIES; i++)
         if (alarm_is_type_a(slot_id[i])) r.type_a = 1'b1;
      step_rsp.push_back(r);
   endfunction

   // update the shadow table for one request and collect its responses
   function automatic void apply_to_table(input alarm_req_type r);
      logic [ID_W-1:0] built;
      logic [ID_W-1:0] err_wide;
      int hit;
      int i;
      step_rsp.delete();
      err_wide = {{(ID_W-ERR_W){1'b0}}, r.err};
      built    = (err_wide & err_mask) | (r.origin & origin_mask);
      hit      = -1;
      case (r.action)
         ACT_SET: begin
            for (i = 0; i < ENTRIES; i++)
               if (hit < 0 && slot_id[i] == '0) hit = i;
            if (hit >= 0) begin
               slot_id[hit]   = built;
               slot_time[hit] = r.epoch;
            end
            note_rsp(hit < 0 ? STS_NO_EFFECT : STS_DONE, built, r.epoch, 1'b1);
         end
         ACT_CLEAR: begin
            for (i = 0; i < ENTRIES; i++)
               if (hit < 0 && slot_id[i] == built) hit = i;
            if (hit >= 0) begin
               slot_id[hit]   = '0;
               slot_time[hit] = '0;
            end
            note_rsp(hit < 0 ? STS_NO_EFFECT : STS_DONE, built, r.epoch, 1'b1);
         end
         ACT_LOOKUP: begin
            for (i = 0; i < ENTRIES; i++)
               if (hit < 0 && (slot_id[i] & err_mask) == err_wide) hit = i;
            if (hit >= 0) note_rsp(STS_DONE, slot_id[hit], slot_time[hit], 1'b1);
            else note_rsp(STS_NO_EFFECT, '0, '0, 1'b1);
         end
         default: begin
            // walk: one response per occupied slot, the final one marked last
            for (i = 0; i < ENTRIES; i++)
               if (slot_id[i] != '0) note_rsp(STS_DONE, slot_id[i], slot_time[i], 1'b0);
            if (step_rsp.size() == 0) note_rsp(STS_NO_EFFECT, '0, '0, 1'b1);
            else step_rsp[step_rsp.size()-1].last = 1'b1;
         end
      endcase
   endfunction

   function automatic plan_row_type mk_row(input logic [ACT_W-1:0] act,
                                           input logic [ERR_W-1:0] err,
                                           input logic [ID_W-1:0] org,
                                           input logic [TIME_W-1:0] ep,
                                           input int reps, input bit typed, input logic sts,
                                           input logic [ID_W-1:0] id,
                                           input logic [TIME_W-1:0] stamp,
                                           input logic ta);
      plan_row_type p;
      p.req   = '{action: act, err: err, origin: org, epoch: ep};
      p.reps  = reps;
      p.typed = typed;
      p.rsp   = '{status: sts, entry_id: id, stamp: stamp, type_a: ta, last: 1'b1};
      return p;
   endfunction

   // random request, mostly sets and clears of ids that were set earlier
   function automatic alarm_req_type draw_request(input int set_pct);
      alarm_req_type r;
      int pick;
      int k;
      pick    = $urandom_range(0, 99);
      r.epoch = $urandom();
      r.err   = $urandom_range(0, 1) ? ERR_W'($urandom_range(0, 31)) : ERR_W'($urandom());
      r.origin = ($urandom_range(0, 4) < 2) ? {8'h10, 8'($urandom())} : ID_W'($urandom());
      if (pick < set_pct) begin
         r.action = ACT_SET;
         set_log.push_back({r.err, r.origin});
         if (set_log.size() > LOG_DEPTH) void'(set_log.pop_front());
      end else if (pick < 65) begin
         r.action = ACT_CLEAR;
         if (set_log.size() > 0 && $urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, set_log.size() - 1);
            {r.err, r.origin} = set_log[k];
            set_log.delete(k);
         end
      end else if (pick < 85) begin
         r.action = ACT_LOOKUP;
         if (set_log.size() > 0 && $urandom_range(0, 9) < 6) begin
            k = $urandom_range(0, set_log.size() - 1);
            r.err = set_log[k][ERR_W+ID_W-1:ID_W];
         end
      end else begin
         r.action = ACT_WALK;
      end
      return r;
   endfunction

   // drive one request from a falling edge, wait for it to be taken
   task automatic send_request(input alarm_req_type r, input bit typed,
                               input alarm_rsp_type typed_rsp);
      int i;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= r.action;
      req_ch.error_num   <= r.err;
      req_ch.origin_code <= r.origin;
      req_ch.now_epoch   <= r.epoch;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      apply_to_table(r);
      if (typed) owed_rsp.push_back(typed_rsp);
      else for (i = 0; i < step_rsp.size(); i++) owed_rsp.push_back(step_rsp[i]);
      @(negedge clock);
   endtask

   // let the block go idle before touching the mask registers
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (owed_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_masks(input logic [ID_W-1:0] em, input logic [ID_W-1:0] om);
      csr_we    <= 1'b1;
      csr_index <= CSR_ERR_MASK;
      csr_wdata <= em;
      @(negedge clock);
      csr_index <= CSR_ORIGIN_MASK;
      csr_wdata <= om;
      @(negedge clock);
      csr_we      <= 1'b0;
      err_mask    = em;
      origin_mask = om;
   endtask

   // response side stalls
   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

   // response checker
   always @(posedge clock) begin
      alarm_rsp_type got;
      alarm_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status   = rsp_ch.status;
         got.entry_id = rsp_ch.entry_id;
         got.stamp    = rsp_ch.stamp;
         got.type_a   = rsp_ch.type_a_present;
         got.last     = rsp_ch.last;
         if (owed_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected response: sts=%0d id=%h stamp=%h ta=%0d last=%0d",
                        got.status, got.entry_id, got.stamp, got.type_a, got.last);
         end else begin
            want = owed_rsp.pop_front();
            if (got.status !== want.status || got.entry_id !== want.entry_id ||
                got.stamp !== want.stamp || got.type_a !== want.type_a ||
                got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("response mismatch: exp sts=%0d id=%h stamp=%h ta=%0d last=%0d",
                           want.status, want.entry_id, want.stamp, want.type_a, want.last);
                  $display("                   got sts=%0d id=%h stamp=%h ta=%0d last=%0d",
                           got.status, got.entry_id, got.stamp, got.type_a, got.last);
               end
            end
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int row;
      int rep;
      int ph;
      int n;
      int set_pct;
      logic [ID_W-1:0] em;
      logic [ID_W-1:0] om;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_SET;
      req_ch.error_num   = '0;
      req_ch.origin_code = '0;
      req_ch.now_epoch   = '0;
      rsp_ch.ready       = 1'b0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      mismatch_count     = 0;
      quiet_cycles       = 0;
      err_mask           = ERR_MASK_RST;
      origin_mask        = ORIGIN_MASK_RST;
      for (n = 0; n < ENTRIES; n++) begin
         slot_id[n]   = '0;
         slot_time[n] = '0;
      end

      // directed requests under the reset masks
      plan[0]  = mk_row(ACT_WALK,   8'h00, 16'h0000, 32'h0,        1,  1,
                        STS_NO_EFFECT, 16'h0000, 32'h0,        1'b0);
      plan[1]  = mk_row(ACT_LOOKUP, 8'h00, 16'h0000, 32'h0,        1,  1,
                        STS_DONE,      16'h0000, 32'h0,        1'b0);
      plan[2]  = mk_row(ACT_LOOKUP, 8'h05, 16'h0000, 32'h0,        1,  1,
                        STS_NO_EFFECT, 16'h0000, 32'h0,        1'b0);
      plan[3]  = mk_row(ACT_CLEAR,  8'h05, 16'h1234, 32'hFFFFFFFF, 1,  1,
                        STS_NO_EFFECT, 16'h1205, 32'hFFFFFFFF, 1'b0);
      plan[4]  = mk_row(ACT_SET,    8'h02, 16'h10AB, 32'hFFFFFFFF, 1,  1,
                        STS_DONE,      16'h1002, 32'hFFFFFFFF, 1'b1);
      plan[5]  = mk_row(ACT_SET,    8'hFF, 16'hFFFF, 32'h0,        1,  1,
                        STS_DONE,      16'hFFFF, 32'h0,        1'b1);
      // zero id lands in the lowest empty slot, which stays empty with a new time
      plan[6]  = mk_row(ACT_SET,    8'h00, 16'h00FF, 32'h12345678, 1,  1,
                        STS_DONE,      16'h0000, 32'h12345678, 1'b1);
      plan[7]  = mk_row(ACT_LOOKUP, 8'h00, 16'h0000, 32'h0,        1,  1,
                        STS_DONE,      16'h0000, 32'h12345678, 1'b1);
      plan[8]  = mk_row(ACT_WALK,   8'h00, 16'h0000, 32'h0,        1,  0,
                        STS_DONE,      16'h0,    32'h0,        1'b0);
      plan[9]  = mk_row(ACT_CLEAR,  8'h00, 16'h0000, 32'hA5A5A5A5, 1,  1,
                        STS_DONE,      16'h0000, 32'hA5A5A5A5, 1'b1);
      plan[10] = mk_row(ACT_LOOKUP, 8'hFF, 16'h0000, 32'h0,        1,  1,
                        STS_DONE,      16'hFFFF, 32'h0,        1'b1);
      plan[11] = mk_row(ACT_CLEAR,  8'h02, 16'h1000, 32'h7,        1,  1,
                        STS_DONE,      16'h1002, 32'h7,        1'b0);
      plan[12] = mk_row(ACT_SET,    8'h14, 16'h1000, 32'h11,       1,  0,
                        STS_DONE,      16'h0,    32'h0,        1'b0);
      plan[13] = mk_row(ACT_SET,    8'h10, 16'h1000, 32'h22,       1,  0,
                        STS_DONE,      16'h0,    32'h0,        1'b0);
      plan[14] = mk_row(ACT_SET,    8'h0F, 16'h1000, 32'h33,       1,  0,
                        STS_DONE,      16'h0,    32'h0,        1'b0);
      plan[15] = mk_row(ACT_SET,    8'h0E, 16'h1000, 32'h44,       1,  0,
                        STS_DONE,      16'h0,    32'h0,        1'b0);
      // fill the rest of the table
      plan[16] = mk_row(ACT_SET,    8'h08, 16'h1000, 32'h80000000, 15, 0,
                        STS_DONE,      16'h0,    32'h0,        1'b0);
      // sets on a full table, zero id included
      plan[17] = mk_row(ACT_SET,    8'h77, 16'h4400, 32'hDEADBEEF, 1,  1,
                        STS_NO_EFFECT, 16'h4477, 32'hDEADBEEF, 1'b1);
      plan[18] = mk_row(ACT_SET,    8'h00, 16'h0000, 32'h1,        1,  1,
                        STS_NO_EFFECT, 16'h0000, 32'h1,        1'b1);
      plan[19] = mk_row(ACT_WALK,   8'h00, 16'h0000, 32'h0,        1,  0,
                        STS_DONE,      16'h0,    32'h0,        1'b0);
      plan[20] = mk_row(ACT_LOOKUP, 8'h08, 16'h0000, 32'h0,        1,  0,
                        STS_DONE,      16'h0,    32'h0,        1'b0);
      plan[21] = mk_row(ACT_CLEAR,  8'h0E, 16'h1000, 32'h55AA55AA, 1,  1,
                        STS_DONE,      16'h100E, 32'h55AA55AA, 1'b1);
      plan[22] = mk_row(ACT_CLEAR,  8'h01, 16'h1000, 32'h9,        1,  0,
                        STS_DONE,      16'h0,    32'h0,        1'b0);
      plan[23] = mk_row(ACT_LOOKUP, 8'h0E, 16'h0000, 32'h0,        1,  0,
                        STS_DONE,      16'h0,    32'h0,        1'b0);
      plan[24] = mk_row(ACT_WALK,   8'h00, 16'h0000, 32'h0,        1,  0,
                        STS_DONE,      16'h0,    32'h0,        1'b0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row = 0; row < NROWS; row++)
         for (rep = 0; rep < plan[row].reps; rep++)
            send_request(plan[row].req, plan[row].typed, plan[row].rsp);
      drain_responses();

      // random phases, each with its own masks and one of four idle patterns
      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin em = ERR_MASK_RST; om = ORIGIN_MASK_RST; end
            1: begin em = 16'hFFFF; om = 16'h0000; end
            2: begin em = 16'h0000; om = 16'hFFFF; end
            3: begin em = 16'h0F0F; om = 16'hF0F0; end
            4: begin em = 16'hFFFF; om = 16'hFFFF; end
            5: begin em = 16'h0000; om = 16'h0000; end
            default: begin
               em = ID_W'($urandom());
               om = ID_W'($urandom());
            end
         endcase
         write_masks(em, om);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         // alternate filling and draining the table
         set_pct = (ph % 2 == 0) ? 45 : 25;
         for (n = 0; n < PHASE_ITEMS; n++)
            send_request(draw_request(set_pct), 1'b0, '0);
         drain_responses();
      end

      if (mismatch_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
